[src/cpwc_pkg.sv]
`timescale 1ns / 1ps

package cpwc_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_POSITION_GAIN          = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_POSITION_INTEGRAL_GAIN = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VELOCITY_GAIN          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDUP_LIMIT           = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIVE_CAP              = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TICK_SECONDS           = 3'd5;

    localparam int TUSER_OUTER_ENABLE  = 0;
    localparam int TUSER_VELOCITY_LOAD = 1;

    typedef struct packed {
        logic               en;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } mul_req_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [63:0] max_v;
        logic signed [63:0] min_v;
        max_v = 64'sd2147483647;
        min_v = -64'sd2147483648;
        if (x > max_v)
            return 32'sh7fff_ffff;
        else if (x < min_v)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

endpackage

[src/cpwc_mul.sv]
`timescale 1ns / 1ps

module cpwc_mul (
    input  logic                 clk,
    input  cpwc_pkg::mul_req_t   req,
    output logic signed [63:0]   product
);
    import cpwc_pkg::*;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            product <= 64'(req.a) * 64'(req.b);
        end
    end

endmodule

[src/cascaded_pi_wheel_controller_top.sv]
`timescale 1ns / 1ps
// An accepted word passes S_PERR, then S_MUL_I, S_INTEG, S_MUL_P, S_MUL_K and S_SETP
// when the position loop is on, then S_VERR, S_MUL_V, S_ACC and S_OUT; one 32x32
// multiplier is reused for every product in sequence. s_tready is low while a word is
// in work, and a finished result waits in the output register.
// Reset: asynchronous, active low; gains, limits and state clear to zero, drive_cap to 255.

module cascaded_pi_wheel_controller_top #(
    parameter int FRACTION_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic [cpwc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cpwc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] target_position, [63:32] sensed_position,
    // [95:64] sensed_velocity, [127:96] commanded_velocity
    input  logic [127:0] s_tdata,
    // [0] outer_enable, [1] velocity_load
    input  logic [1:0]   s_tuser,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] drive_value, [47:16] velocity_setpoint
    output logic [47:0]  m_tdata
);
    import cpwc_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PERR  = 11'b00000000010,
        S_MUL_I = 11'b00000000100,
        S_INTEG = 11'b00000001000,
        S_MUL_P = 11'b00000010000,
        S_MUL_K = 11'b00000100000,
        S_SETP  = 11'b00001000000,
        S_VERR  = 11'b00010000000,
        S_MUL_V = 11'b00100000000,
        S_ACC   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    localparam logic signed [32:0] TRUNC_BIAS = 33'((64'd1 << FRACTION_BITS) - 64'd1);

    state_t state_reg, state_next;

    logic signed [31:0] position_gain_reg;
    logic signed [31:0] position_integral_gain_reg;
    logic signed [31:0] velocity_gain_reg;
    logic        [30:0] windup_limit_reg;
    logic signed [15:0] drive_cap_reg;
    logic        [30:0] tick_seconds_reg;

    logic signed [31:0] position_integral_reg;
    logic signed [31:0] drive_accumulator_reg;
    logic signed [31:0] held_velocity_setpoint_reg;

    logic signed [31:0] target_reg;
    logic signed [31:0] sensed_position_reg;
    logic signed [31:0] sensed_velocity_reg;
    logic               outer_enable_reg;
    logic signed [31:0] error_reg;
    logic signed [63:0] partial_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_drive_reg;
    logic signed [31:0] out_setpoint_reg;

    mul_req_t           mul_req;
    logic signed [63:0] product;
    logic signed [63:0] product_shifted;

    logic               s_accept;
    logic               out_free;
    logic signed [32:0] integral_wide;
    logic signed [32:0] limit_wide;
    logic               integrate_ok;
    logic signed [63:0] drive_sum;
    logic signed [63:0] cap_q;
    logic signed [32:0] drive_trunc;
    logic signed [15:0] drive_sat;

    cpwc_mul u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    assign s_tready        = (state_reg == S_IDLE);
    assign s_accept        = s_tvalid && s_tready;
    assign out_free        = !out_valid_reg || m_tready;
    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {out_setpoint_reg, out_drive_reg};
    assign product_shifted = product >>> FRACTION_BITS;

    assign integral_wide = 33'(position_integral_reg);
    assign limit_wide    = $signed({2'b00, windup_limit_reg});
    assign integrate_ok  = (integral_wide <= limit_wide) && (integral_wide >= -limit_wide);

    assign drive_sum = 64'(drive_accumulator_reg) + product_shifted;
    assign cap_q     = 64'(drive_cap_reg) <<< FRACTION_BITS;

    // truncate toward zero: bias negative values before the arithmetic shift
    always_comb
    begin
        if (drive_accumulator_reg < 0)
            drive_trunc = (33'(drive_accumulator_reg) + TRUNC_BIAS) >>> FRACTION_BITS;
        else
            drive_trunc = 33'(drive_accumulator_reg) >>> FRACTION_BITS;
        if (drive_trunc > 33'sd32767)
            drive_sat = 16'sh7fff;
        else if (drive_trunc < -33'sd32768)
            drive_sat = 16'sh8000;
        else
            drive_sat = drive_trunc[15:0];
    end

    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            S_MUL_I:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = error_reg;
                mul_req.b  = $signed({1'b0, tick_seconds_reg});
            end
            S_MUL_P:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = position_gain_reg;
                mul_req.b  = error_reg;
            end
            S_MUL_K:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = position_integral_gain_reg;
                mul_req.b  = position_integral_reg;
            end
            S_MUL_V:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = velocity_gain_reg;
                mul_req.b  = error_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_accept) state_next = S_PERR;
            S_PERR:  state_next = outer_enable_reg ? S_MUL_I : S_VERR;
            S_MUL_I: state_next = S_INTEG;
            S_INTEG: state_next = S_MUL_P;
            S_MUL_P: state_next = S_MUL_K;
            S_MUL_K: state_next = S_SETP;
            S_SETP:  state_next = S_VERR;
            S_VERR:  state_next = S_MUL_V;
            S_MUL_V: state_next = S_ACC;
            S_ACC:   state_next = S_OUT;
            S_OUT:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                  <= S_IDLE;
            out_valid_reg              <= 1'b0;
            position_gain_reg          <= '0;
            position_integral_gain_reg <= '0;
            velocity_gain_reg          <= '0;
            windup_limit_reg           <= '0;
            drive_cap_reg              <= 16'sd255;
            tick_seconds_reg           <= '0;
            position_integral_reg      <= '0;
            drive_accumulator_reg      <= '0;
            held_velocity_setpoint_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_POSITION_GAIN:          position_gain_reg <= cfg_data;
                    CFG_POSITION_INTEGRAL_GAIN: position_integral_gain_reg <= cfg_data;
                    CFG_VELOCITY_GAIN:          velocity_gain_reg <= cfg_data;
                    CFG_WINDUP_LIMIT:           windup_limit_reg <= cfg_data[30:0];
                    CFG_DRIVE_CAP:              drive_cap_reg <= cfg_data[15:0];
                    CFG_TICK_SECONDS:           tick_seconds_reg <= cfg_data[30:0];
                    default:                    ;
                endcase
            end

            // load the commanded velocity as the word is taken
            if (s_accept && s_tuser[TUSER_VELOCITY_LOAD])
                held_velocity_setpoint_reg <= s_tdata[127:96];

            if (state_reg == S_INTEG && integrate_ok)
                position_integral_reg <= sat32(64'(position_integral_reg) + product_shifted);

            if (state_reg == S_SETP)
                held_velocity_setpoint_reg <= sat32(partial_reg + product_shifted);

            if (state_reg == S_ACC)
            begin
                if (drive_sum < cap_q)
                    drive_accumulator_reg <= sat32(drive_sum);
                else
                    drive_accumulator_reg <= sat32(cap_q);
            end

            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            target_reg          <= s_tdata[31:0];
            sensed_position_reg <= s_tdata[63:32];
            sensed_velocity_reg <= s_tdata[95:64];
            outer_enable_reg    <= s_tuser[TUSER_OUTER_ENABLE];
        end
        if (state_reg == S_PERR)
            error_reg <= sat32(64'(target_reg) - 64'(sensed_position_reg));
        if (state_reg == S_VERR)
            error_reg <= sat32(64'(held_velocity_setpoint_reg) - 64'(sensed_velocity_reg));
        // hold the proportional term while the integral product is formed
        if (state_reg == S_MUL_K)
            partial_reg <= product_shifted;
        if (state_reg == S_OUT && out_free)
        begin
            out_drive_reg    <= drive_sat;
            out_setpoint_reg <= held_velocity_setpoint_reg;
        end
    end

endmodule

[src/cpwc_checker.sv]
`timescale 1ns / 1ps

module cpwc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // a taken word closes the input side behind it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
        else $error("input accepted again too soon");

    // a new result shows only at the end of work, never while idle
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work in progress");

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind cascaded_pi_wheel_controller_top cpwc_checker u_checker (.*);

[sim/cascaded_pi_wheel_controller_top_test.sv]
`timescale 1ns / 1ps

module cascaded_pi_wheel_controller_top_test;
    import cpwc_pkg::*;

    localparam int FRAC_BITS      = 16;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_PRINTED    = 100;
    localparam int DRAIN_CYCLES   = 12;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 46;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_7 = 3'd7;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam longint L32_MAX = 64'sd2147483647;
    localparam longint L32_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [31:0] target_pos;
        logic signed [31:0] sensed_pos;
        logic signed [31:0] sensed_vel;
        logic               outer_en;
        logic               vel_load;
        logic signed [31:0] commanded_vel;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic signed [31:0] setpoint;
    } wheel_out_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    // [31:0] target_position, [63:32] sensed_position,
    // [95:64] sensed_velocity, [127:96] commanded_velocity
    logic [127:0] s_tdata;
    // [0] outer_enable, [1] velocity_load
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // [15:0] drive_value, [47:16] velocity_setpoint
    logic [47:0]  m_tdata;

    // controller registers and state as the block should hold them
    longint kp_pos;
    longint ki_pos;
    longint kp_vel;
    longint windup;
    longint cap;
    longint dt;
    longint pos_integral;
    longint drive_acc;
    longint held_setpoint;

    wheel_out_t wheel_out_q[$];
    wheel_out_t due;
    logic signed [15:0] got_drive;
    logic signed [31:0] got_setpoint;

    logic calm;
    int   mismatches;
    int   ticks_sent;
    int   outputs_checked;
    int   reg_writes;
    int   idle_cycles;

    cascaded_pi_wheel_controller_top #(
        .FRACTION_BITS(FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint clamp32(input longint x);
        if (x > L32_MAX)
            return L32_MAX;
        if (x < L32_MIN)
            return L32_MIN;
        return x;
    endfunction

    // One control tick: optional load, optional position loop, then the velocity loop.
    function automatic wheel_out_t advance_wheel(input tick_t t);
        longint pos_err;
        longint vel_err;
        longint sum;
        longint cap_q;
        longint drive;
        wheel_out_t r;
        if (t.vel_load)
            held_setpoint = t.commanded_vel;
        if (t.outer_en)
        begin
            pos_err = clamp32(longint'(t.target_pos) - longint'(t.sensed_pos));
            // integrate only inside the windup window
            if (pos_integral <= windup && pos_integral >= -windup)
                pos_integral = clamp32(pos_integral + ((pos_err * dt) >>> FRAC_BITS));
            held_setpoint = clamp32(((kp_pos * pos_err) >>> FRAC_BITS) +
                                    ((ki_pos * pos_integral) >>> FRAC_BITS));
        end
        vel_err = clamp32(held_setpoint - longint'(t.sensed_vel));
        sum     = drive_acc + ((kp_vel * vel_err) >>> FRAC_BITS);
        cap_q   = cap * (64'sd1 <<< FRAC_BITS);
        drive_acc = (sum < cap_q) ? clamp32(sum) : clamp32(cap_q);
        // drive truncates toward zero, unlike the products
        drive = (drive_acc >= 0) ? (drive_acc >>> FRAC_BITS) : -((-drive_acc) >>> FRAC_BITS);
        if (drive > 32767)
            drive = 32767;
        if (drive < -32768)
            drive = -32768;
        r.drive    = drive[15:0];
        r.setpoint = held_setpoint[31:0];
        return r;
    endfunction

    function automatic logic idle_roll();
        return !calm && ($urandom_range(99) < 37);
    endfunction

    function automatic logic signed [31:0] rand_span(input int span);
        int v;
        v = int'($urandom_range(2 * span)) - span;
        return v;
    endfunction

    function automatic tick_t make_tick(input logic signed [31:0] target_pos,
                                        input logic signed [31:0] sensed_pos,
                                        input logic signed [31:0] sensed_vel,
                                        input logic outer_en,
                                        input logic vel_load,
                                        input logic signed [31:0] commanded_vel);
        tick_t t;
        t.target_pos    = target_pos;
        t.sensed_pos    = sensed_pos;
        t.sensed_vel    = sensed_vel;
        t.outer_en      = outer_en;
        t.vel_load      = vel_load;
        t.commanded_vel = commanded_vel;
        return t;
    endfunction

    // Mostly plausible wheel motion, some words with fully random fields.
    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(4) == 0)
        begin
            t.target_pos    = $urandom;
            t.sensed_pos    = $urandom;
            t.sensed_vel    = $urandom;
            t.commanded_vel = $urandom;
        end
        else
        begin
            t.target_pos    = rand_span(100 * 65536);
            t.sensed_pos    = t.target_pos + rand_span(2 * 65536);
            t.sensed_vel    = rand_span(20 * 65536);
            t.commanded_vel = rand_span(20 * 65536);
        end
        t.outer_en = $urandom_range(9) < 7;
        t.vel_load = $urandom_range(9) < 3;
        return t;
    endfunction

    function automatic logic [31:0] random_gain();
        int r;
        r = $urandom_range(9);
        if (r < 7)
            return rand_span(4 * 65536);
        if (r == 7)
            return $urandom;
        return (r == 8) ? S32_MAX : S32_MIN;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t mismatch: %s", $time, what);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        reg_writes++;
        // upper bits beyond each register's width drop
        case (index)
            CFG_POSITION_GAIN:          kp_pos = longint'($signed(data));
            CFG_POSITION_INTEGRAL_GAIN: ki_pos = longint'($signed(data));
            CFG_VELOCITY_GAIN:          kp_vel = longint'($signed(data));
            CFG_WINDUP_LIMIT:           windup = longint'({1'b0, data[30:0]});
            CFG_DRIVE_CAP:              cap    = longint'($signed(data[15:0]));
            CFG_TICK_SECONDS:           dt     = longint'({1'b0, data[30:0]});
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [31:0] kp, input logic [31:0] ki,
                             input logic [31:0] kv, input logic [31:0] limit,
                             input logic [31:0] drive_cap, input logic [31:0] seconds);
        write_register(CFG_POSITION_GAIN, kp);
        write_register(CFG_POSITION_INTEGRAL_GAIN, ki);
        write_register(CFG_VELOCITY_GAIN, kv);
        write_register(CFG_WINDUP_LIMIT, limit);
        write_register(CFG_DRIVE_CAP, drive_cap);
        write_register(CFG_TICK_SECONDS, seconds);
    endtask

    // Hold tvalid until the word is taken; tvalid stays up for a back-to-back word.
    task automatic send_tick(input tick_t t);
        logic [1:0] user;
        user = '0;
        user[TUSER_OUTER_ENABLE]  = t.outer_en;
        user[TUSER_VELOCITY_LOAD] = t.vel_load;
        while (idle_roll())
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.commanded_vel, t.sensed_vel, t.sensed_pos, t.target_pos};
        s_tuser  <= user;
        do
            @(posedge clk);
        while (!s_tready);
        wheel_out_q.push_back(advance_wheel(t));
        ticks_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (wheel_out_q.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_reset_state();
        // all gains zero: loads pass through, the loop drives the setpoint to zero
        send_tick(make_tick(0, 0, 0, 1'b0, 1'b1, S32_MAX));
        send_tick(make_tick(S32_MAX, S32_MIN, S32_MIN, 1'b0, 1'b0, 0));
        send_tick(make_tick(S32_MAX, S32_MIN, S32_MAX, 1'b1, 1'b1, S32_MIN));
        // only the velocity gain written, so the cap still holds its reset value
        drain_results();
        write_register(CFG_VELOCITY_GAIN, Q_ONE);
        send_tick(make_tick(0, 0, 0, 1'b0, 1'b1, 300 * 65536));
    endtask

    task automatic test_anti_windup();
        drain_results();
        write_all(0, Q_ONE, 0, 32'h0001_8000, 32'd255, 32'h0000_8000);
        // integral climbs in half steps until it leaves the window, then freezes
        repeat (5)
            send_tick(make_tick(Q_ONE, 0, 0, 1'b1, 1'b0, 0));
        send_tick(make_tick(0, Q_ONE, 0, 1'b1, 1'b0, 0));
    endtask

    task automatic test_extremes();
        drain_results();
        write_all(S32_MAX, S32_MAX, S32_MAX, 32'hffff_ffff, 32'habcd_7fff, 32'hffff_ffff);
        write_register(CFG_SPARE_6, 32'hdead_beef);
        write_register(CFG_SPARE_7, 32'h1234_5678);
        // position error overflows high; integral, loop output and drive all pin high
        send_tick(make_tick(S32_MAX, S32_MIN, 0, 1'b1, 1'b0, 0));

        // integral outside a zero window; error overflows low
        drain_results();
        write_register(CFG_WINDUP_LIMIT, 32'h0);
        write_register(CFG_POSITION_INTEGRAL_GAIN, S32_MIN);
        send_tick(make_tick(S32_MIN, S32_MAX, S32_MAX, 1'b1, 1'b0, 0));

        // load and loop together: the loop wins, integral falls back to zero
        drain_results();
        write_register(CFG_WINDUP_LIMIT, 32'h7fff_ffff);
        send_tick(make_tick(0, Q_ONE, 0, 1'b1, 1'b1, S32_MAX));

        // most negative cap meets an accumulator pinned at the bottom
        drain_results();
        write_register(CFG_VELOCITY_GAIN, S32_MIN);
        write_register(CFG_DRIVE_CAP, 32'h0000_8000);
        send_tick(make_tick(0, 0, 0, 1'b0, 1'b1, 0));
        send_tick(make_tick(0, 0, S32_MAX, 1'b0, 1'b0, 0));

        // small negative cap; climb into it, then fall with a fractional step
        drain_results();
        write_register(CFG_VELOCITY_GAIN, 32'h0000_8000);
        write_register(CFG_DRIVE_CAP, 32'hffff_fffb);
        send_tick(make_tick(0, 0, -(10 * 65536), 1'b0, 1'b1, 0));
        send_tick(make_tick(0, 0, S32_MIN + 1, 1'b0, 1'b0, 0));
        send_tick(make_tick(0, 0, S32_MIN + 1, 1'b0, 1'b0, 0));
        send_tick(make_tick(0, 0, 3 * 65536 + 1, 1'b0, 1'b0, 0));
    endtask

    task automatic test_full_rate();
        drain_results();
        calm = 1'b1;
        repeat (32)
            send_tick(random_tick());
        calm = 1'b0;
    endtask

    task automatic test_random_ticks();
        logic [31:0] limit;
        logic [31:0] drive_cap;
        logic [31:0] seconds;
        int r;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            if (phase == 0)
                write_all(2 * Q_ONE, 32'h0000_4000, 32'h0000_8000,
                          50 * 65536, 32'd200, 32'd66);
            else
            begin
                r = $urandom_range(9);
                limit = (r < 6) ? 32'($urandom_range(100 * 65536)) :
                        (r < 8) ? 32'($urandom) : 32'hffff_ffff;
                r = $urandom_range(9);
                drive_cap = (r < 6) ? 32'(rand_span(1000)) :
                            (r < 8) ? 32'($urandom) :
                            (r == 8) ? 32'h0000_7fff : 32'h0000_8000;
                r = $urandom_range(9);
                seconds = (r < 6) ? 32'($urandom_range(4096, 1)) :
                          (r < 8) ? 32'($urandom) :
                          (r == 8) ? 32'h0 : 32'hffff_ffff;
                write_all(random_gain(), random_gain(), random_gain(),
                          limit, drive_cap, seconds);
                if ($urandom_range(1) == 1)
                    write_register(CFG_SPARE_6, $urandom);
            end
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // hold off mid-phase until every result is back
                if (phase == 3 && n == PHASE_TICKS / 2)
                    drain_results();
                send_tick(random_tick());
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (wheel_out_q.size() == 0)
                report_mismatch("result word with no tick pending");
            else
            begin
                due          = wheel_out_q.pop_front();
                got_drive    = m_tdata[15:0];
                got_setpoint = m_tdata[47:16];
                outputs_checked++;
                if (got_drive !== due.drive)
                    report_mismatch($sformatf("drive_value got %0d want %0d",
                                              got_drive, due.drive));
                if (got_setpoint !== due.setpoint)
                    report_mismatch($sformatf("velocity_setpoint got %0d want %0d",
                                              got_setpoint, due.setpoint));
            end
        end
        m_tready <= rst_n && !idle_roll();
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        calm            = 1'b0;
        mismatches      = 0;
        ticks_sent      = 0;
        outputs_checked = 0;
        reg_writes      = 0;
        idle_cycles     = 0;
        kp_pos          = 0;
        ki_pos          = 0;
        kp_vel          = 0;
        windup          = 0;
        cap             = 255;
        dt              = 0;
        pos_integral    = 0;
        drive_acc       = 0;
        held_setpoint   = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_anti_windup();
        test_extremes();
        test_full_rate();
        test_random_ticks();

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d ticks sent, %0d result words checked, %0d register writes",
                 ticks_sent, outputs_checked, reg_writes);
        $display("summary: overflow, windup and cap corners, then %0d random gain settings",
                 RANDOM_PHASES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[cascaded_pi_wheel_controller_top.f]
src/cpwc_pkg.sv
src/cpwc_mul.sv
src/cascaded_pi_wheel_controller_top.sv
src/cpwc_checker.sv
sim/cascaded_pi_wheel_controller_top_test.sv
